@@ src/sensor_frame_crc_convert_core_macros.svh @@
// Assertion macros for the sensor frame CRC/convert block.
// Used by the checker only; no other dependencies.
`ifndef SENSOR_FRAME_CRC_CONVERT_CORE_MACROS_SVH
`define SENSOR_FRAME_CRC_CONVERT_CORE_MACROS_SVH

// Checked only outside reset.
`define SFCC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sfcc check failed");

// Checked on every edge, reset included.
`define SFCC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("sfcc check failed");

`endif

@@ src/sfcc_pkg.sv @@
// Shared types, constants and CRC function for the sensor frame block.
// No dependencies.
package sfcc_pkg;

  // byte position codes within a frame
  localparam logic [1:0] POS_HIGH  = 2'd0;
  localparam logic [1:0] POS_LOW   = 2'd1;
  localparam logic [1:0] POS_CHECK = 2'd2;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [15:0] STATUS_MASK = 16'h0003;

  localparam logic [14:0] TEMP_SCALE = 15'd17572;
  localparam logic [14:0] HUM_SCALE  = 15'd12500;
  localparam logic signed [14:0] TEMP_OFFSET = -15'sd4685;
  localparam logic signed [14:0] HUM_OFFSET  = -15'sd600;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [15:0] raw;
    logic        crc_ok;
    logic        hum;
  } frame_rec_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (r[7]) begin
        r = {r[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

@@ src/sfcc_in_if.sv @@
// Input channel: one received sensor byte per item.
// No dependencies.
interface sfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       kind;

  modport source(output valid, output rx_byte, output kind, input ready);
  modport sink(input valid, input rx_byte, input kind, output ready);
endinterface

@@ src/sfcc_out_if.sv @@
// Result channel: one checked, converted measurement per item.
// No dependencies.
interface sfcc_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        raw_value;
  logic signed [14:0] converted;
  logic               crc_ok;
  logic               was_humidity;

  modport source(output valid, output raw_value, output converted, output crc_ok,
                 output was_humidity, input ready);
  modport sink(input valid, input raw_value, input converted, input crc_ok,
               input was_humidity, output ready);
endinterface

@@ src/sensor_frame_crc_convert_core.sv @@
// Path: a result goes through the queue, the s1 register and the output register.
// Throughput: one byte per cycle sustained, one result per three bytes;
// input stalls only when the frame queue is full on a checksum byte.
// Reset (rst, synchronous, active high): byte position back to frame start,
// queue emptied, all pipeline valid flags cleared.
// Top level: front end -> frame queue -> back end.
module sensor_frame_crc_convert_core #(
  parameter int QUEUE_DEPTH = sfcc_pkg::QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst,
  sfcc_in_if.sink    frame_byte,
  sfcc_out_if.source result
);

  // Front end: tracks the byte position (high, low, checksum), keeps the
  // two data bytes and the running CRC-8, and on the checksum byte pushes
  // a finished frame record (raw value, CRC match, kind) into the queue.
  logic                 push_valid, push_ready;
  sfcc_pkg::frame_rec_t push_data;

  // Queue output toward the back end.
  logic                 pop_valid, pop_ready;
  sfcc_pkg::frame_rec_t pop_data;

  sfcc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .frame_byte (frame_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Short queue so a stalled result side does not hold up byte intake.
  sfcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: one registered 16x15 multiply by the kind's scale, take the
  // upper 15 bits (floor of /65536), then add the kind's offset into the
  // output register.
  sfcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

@@ src/sfcc_front.sv @@
// Front end: frame byte tracking, CRC, frame record build.
// Depends on sfcc_pkg and sfcc_in_if.
module sfcc_front (
  input  logic                clk,
  input  logic                rst,
  sfcc_in_if.sink             frame_byte,
  output logic                push_valid,
  input  logic                push_ready,
  output sfcc_pkg::frame_rec_t push_data
);

  logic [1:0] pos, pos_next;
  logic [7:0] crc, crc_next;
  logic [7:0] held_hi, held_lo;
  logic       accept;

  // position 3 is unreachable and behaves as a frame start
  assign frame_byte.ready = (pos != sfcc_pkg::POS_CHECK) || push_ready;
  assign accept = frame_byte.valid && frame_byte.ready;
  assign push_valid = frame_byte.valid && (pos == sfcc_pkg::POS_CHECK);

  assign push_data.raw    = {held_hi, held_lo} & ~sfcc_pkg::STATUS_MASK;
  assign push_data.crc_ok = (crc == frame_byte.rx_byte);
  assign push_data.hum    = frame_byte.kind;

  always_comb begin
    pos_next = pos;
    crc_next = crc;
    unique case (pos)
      sfcc_pkg::POS_LOW: begin
        pos_next = sfcc_pkg::POS_CHECK;
        crc_next = sfcc_pkg::crc8_byte(crc, frame_byte.rx_byte);
      end
      sfcc_pkg::POS_CHECK: begin
        pos_next = sfcc_pkg::POS_HIGH;
        crc_next = '0;
      end
      default: begin
        pos_next = sfcc_pkg::POS_LOW;
        crc_next = sfcc_pkg::crc8_byte(8'h00, frame_byte.rx_byte);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= sfcc_pkg::POS_HIGH;
      crc <= '0;
    end else if (accept) begin
      pos <= pos_next;
      crc <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pos == sfcc_pkg::POS_LOW)) begin
      held_lo <= frame_byte.rx_byte;
    end
    if (accept && (pos != sfcc_pkg::POS_LOW) && (pos != sfcc_pkg::POS_CHECK)) begin
      held_hi <= frame_byte.rx_byte;
    end
  end

endmodule

@@ src/sfcc_queue.sv @@
// Short FIFO of frame records between front and back end.
// Depends on sfcc_pkg.
module sfcc_queue #(
  parameter int DEPTH = sfcc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  sfcc_pkg::frame_rec_t push_data,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output sfcc_pkg::frame_rec_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  sfcc_pkg::frame_rec_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/sfcc_back.sv @@
// Back end: scale multiply, offset add, output register.
// Depends on sfcc_pkg and sfcc_out_if.
module sfcc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  sfcc_pkg::frame_rec_t pop_data,
  sfcc_out_if.source           result
);

  logic [30:0] prod;
  logic        s1_valid;
  logic [14:0] s1_quot;
  logic [15:0] s1_raw;
  logic        s1_crc, s1_hum;
  logic        out_free, s1_free;
  logic signed [15:0] sum;

  assign out_free  = !result.valid || result.ready;
  assign s1_free   = !s1_valid || out_free;
  assign pop_ready = s1_free;

  assign prod = 31'(pop_data.raw) *
                31'(pop_data.hum ? sfcc_pkg::HUM_SCALE : sfcc_pkg::TEMP_SCALE);

  assign sum = 16'(signed'({1'b0, s1_quot})) +
               16'(s1_hum ? sfcc_pkg::HUM_OFFSET : sfcc_pkg::TEMP_OFFSET);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= pop_valid;
      end
      if (out_free) begin
        result.valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && pop_valid) begin
      s1_quot <= prod[30:16];
      s1_raw  <= pop_data.raw;
      s1_crc  <= pop_data.crc_ok;
      s1_hum  <= pop_data.hum;
    end
    if (out_free && s1_valid) begin
      result.raw_value    <= s1_raw;
      result.converted    <= sum[14:0];
      result.crc_ok       <= s1_crc;
      result.was_humidity <= s1_hum;
    end
  end

endmodule

@@ src/sfcc_checker.sv @@
// Port-level checks for the sensor frame CRC/convert top level, with bind.
// Depends on sensor_frame_crc_convert_core_macros.svh.
`include "sensor_frame_crc_convert_core_macros.svh"

module sfcc_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [15:0]        raw_value,
  input logic signed [14:0] converted
);

  // status bits are always cleared in a result
  `SFCC_ASSERT(a_status_clear, clk, rst, out_valid |-> (raw_value[1:0] == 2'b00))

  // converted value stays within the range of both conversions
  `SFCC_ASSERT(a_conv_range, clk, rst,
    out_valid |-> (($signed(converted) >= -15'sd4685) && ($signed(converted) <= 15'sd12885)))

  // a stalled result holds
  `SFCC_ASSERT(a_out_hold, clk, rst,
    (out_valid && !out_ready) |=> (out_valid && $stable(raw_value) && $stable(converted)))

  // no result right after reset
  `SFCC_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !out_valid)

endmodule

bind sensor_frame_crc_convert_core sfcc_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .raw_value (result.raw_value),
  .converted (result.converted)
);
